### src/log_pattern_to_glob_macros.svh
// Assertion macros for the log pattern to glob converter.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef LOG_PATTERN_TO_GLOB_MACROS_SVH
`define LOG_PATTERN_TO_GLOB_MACROS_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is asserted
`define LPTG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds while reset is asserted
`define LPTG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPTG_ASSERT(label, prop, msg)
`define LPTG_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### src/lptg_pkg.sv
// Types and character codes for the log pattern to glob converter.
// No dependencies.
`default_nettype none

package lptg_pkg;

    localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
    localparam logic [7:0] CH_STAR = 8'h2A;  // '*'
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_Y    = 8'h59;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_LH   = 8'h68;  // 'h'
    localparam logic [7:0] CH_LM   = 8'h6D;  // 'm'
    localparam logic [7:0] CH_LS   = 8'h73;  // 's'
    localparam logic [7:0] CH_LP   = 8'h70;  // 'p'

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef enum logic [3:0] {
        ST_NORMAL = 4'b0001,
        ST_START  = 4'b0010,
        ST_POST   = 4'b0100,
        ST_DROP   = 4'b1000
    } state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last_of_run;
        logic       pattern_end;
    } result_t;

endpackage

`default_nettype wire

### src/log_pattern_to_glob.sv
// Log file name pattern to glob converter, top level.
// Depends on lptg_pkg and log_pattern_to_glob_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request per pattern
//   character (func = 0, char_in) or an end-of-pattern request (func = 1).
//   Output channel (out_valid/out_stall) carries zero, one or two results
//   per request; last_of_run marks the final result of each request and
//   pattern_end the final result of an end-of-pattern request.
//   A result is registered and appears in the cycle after its request is accepted.
//   One request per cycle while each yields at most one result and out_stall
//   is low; a request yielding two results blocks the next until one is gone.
//   The rate is set by the two-entry result buffer, which takes a new
//   request only once its contents will be gone by the end of the cycle.
//   Reset puts the parser in its plain-character state and empties the
//   buffer. While the receiver stalls, the head result holds and in_stall
//   rises as soon as the buffer cannot drain.
`default_nettype none

`include "log_pattern_to_glob_macros.svh"

module log_pattern_to_glob (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       func,
    input  wire logic [7:0] char_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_char,
    output logic            char_valid,
    output logic            last_of_run,
    output logic            pattern_end
);

    lptg_pkg::state_t  state_reg, state_next;
    lptg_pkg::state_t  dec_state;
    lptg_pkg::result_t slot0_reg, slot0_next;
    lptg_pkg::result_t slot1_reg, slot1_next;
    lptg_pkg::result_t dec_r0, dec_r1;
    logic [1:0]        count_reg, count_next;
    logic [1:0]        dec_n;
    logic              is_escape;
    logic              pop;
    logic              push;

    assign out_valid   = (count_reg != 2'd0);
    assign pop         = out_valid && !out_stall;
    assign in_stall    = !((count_reg == 2'd0) || ((count_reg == 2'd1) && pop));
    assign push        = in_valid && !in_stall;

    assign out_char    = slot0_reg.out_char;
    assign char_valid  = slot0_reg.char_valid;
    assign last_of_run = slot0_reg.last_of_run;
    assign pattern_end = slot0_reg.pattern_end;

    assign is_escape = char_in inside {lptg_pkg::CH_T, lptg_pkg::CH_Y, lptg_pkg::CH_M,
                                       lptg_pkg::CH_D, lptg_pkg::CH_LH, lptg_pkg::CH_LM,
                                       lptg_pkg::CH_LS, lptg_pkg::CH_LP};

    // Decode one request against the current parser state.
    always_comb
    begin
        dec_n     = 2'd0;
        dec_r0    = '0;
        dec_r1    = '0;
        dec_state = state_reg;
        if (func == lptg_pkg::FUNC_END)
        begin
            dec_state = lptg_pkg::ST_NORMAL;
            case (state_reg)
                lptg_pkg::ST_START, lptg_pkg::ST_DROP:
                begin
                    dec_n  = 2'd2;
                    dec_r0 = '{out_char: lptg_pkg::CH_PCT, char_valid: 1'b1,
                               last_of_run: 1'b0, pattern_end: 1'b0};
                    dec_r1 = '{out_char: lptg_pkg::CH_STAR, char_valid: 1'b1,
                               last_of_run: 1'b0, pattern_end: 1'b1};
                end
                lptg_pkg::ST_POST:
                begin
                    // bare end marker
                    dec_n  = 2'd1;
                    dec_r0 = '{out_char: 8'h00, char_valid: 1'b0,
                               last_of_run: 1'b0, pattern_end: 1'b1};
                end
                default:
                begin
                    dec_n  = 2'd1;
                    dec_r0 = '{out_char: lptg_pkg::CH_STAR, char_valid: 1'b1,
                               last_of_run: 1'b0, pattern_end: 1'b1};
                end
            endcase
        end
        else
        begin
            case (state_reg)
                lptg_pkg::ST_POST:
                begin
                    if (char_in == lptg_pkg::CH_PCT)
                    begin
                        dec_state = lptg_pkg::ST_DROP;
                    end
                    else if (char_in != lptg_pkg::CH_STAR)
                    begin
                        dec_n     = 2'd1;
                        dec_r0    = '{out_char: char_in, char_valid: 1'b1,
                                      last_of_run: 1'b0, pattern_end: 1'b0};
                        dec_state = lptg_pkg::ST_NORMAL;
                    end
                end
                lptg_pkg::ST_START, lptg_pkg::ST_DROP:
                begin
                    if (is_escape)
                    begin
                        // drop the wildcard when one was just emitted
                        if (state_reg == lptg_pkg::ST_START)
                        begin
                            dec_n  = 2'd1;
                            dec_r0 = '{out_char: lptg_pkg::CH_STAR, char_valid: 1'b1,
                                       last_of_run: 1'b0, pattern_end: 1'b0};
                        end
                        dec_state = lptg_pkg::ST_POST;
                    end
                    else if (char_in == lptg_pkg::CH_PCT)
                    begin
                        dec_n     = 2'd1;
                        dec_r0    = '{out_char: lptg_pkg::CH_PCT, char_valid: 1'b1,
                                      last_of_run: 1'b0, pattern_end: 1'b0};
                        dec_state = lptg_pkg::ST_NORMAL;
                    end
                    else
                    begin
                        dec_n     = 2'd2;
                        dec_r0    = '{out_char: lptg_pkg::CH_PCT, char_valid: 1'b1,
                                      last_of_run: 1'b0, pattern_end: 1'b0};
                        dec_r1    = '{out_char: char_in, char_valid: 1'b1,
                                      last_of_run: 1'b0, pattern_end: 1'b0};
                        dec_state = (char_in == lptg_pkg::CH_STAR) ? lptg_pkg::ST_POST
                                                                   : lptg_pkg::ST_NORMAL;
                    end
                end
                default:
                begin
                    if (char_in == lptg_pkg::CH_PCT)
                    begin
                        dec_state = lptg_pkg::ST_START;
                    end
                    else
                    begin
                        dec_n     = 2'd1;
                        dec_r0    = '{out_char: char_in, char_valid: 1'b1,
                                      last_of_run: 1'b0, pattern_end: 1'b0};
                        dec_state = (char_in == lptg_pkg::CH_STAR) ? lptg_pkg::ST_POST
                                                                   : lptg_pkg::ST_NORMAL;
                    end
                end
            endcase
        end
        // mark the final result of this request
        if (dec_n == 2'd1)
        begin
            dec_r0.last_of_run = 1'b1;
        end
        if (dec_n == 2'd2)
        begin
            dec_r1.last_of_run = 1'b1;
        end
    end

    // Result buffer: a push only lands when the buffer drains this cycle.
    always_comb
    begin
        state_next = state_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push)
        begin
            state_next = dec_state;
            slot0_next = dec_r0;
            slot1_next = dec_r1;
            count_next = dec_n;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lptg_pkg::ST_NORMAL;
            count_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `LPTG_ASSERT(a_end_to_normal,
        (push && (func == lptg_pkg::FUNC_END)) |=> (state_reg == lptg_pkg::ST_NORMAL),
        "end of pattern did not return parser to normal")
    `LPTG_ASSERT(a_pair_order,
        (count_reg == 2'd2) |-> (!slot0_reg.last_of_run && slot1_reg.last_of_run),
        "two-result run marks last_of_run wrongly")
    `LPTG_ASSERT(a_end_is_last, (out_valid && pattern_end) |-> last_of_run,
        "pattern_end result not last of its run")
    `LPTG_ASSERT(a_bare_marker,
        (out_valid && !char_valid) |-> (pattern_end && (out_char == 8'h00)),
        "bare marker outside end of pattern")
    `LPTG_ASSERT_ALWAYS(a_count_range, !rst_n || (count_reg != 2'd3),
        "result buffer count out of range")

endmodule

`default_nettype wire
